FILE: hw/rtl/ppem_pkg.sv
// Package for the perfect power exponent mask block.
// Holds the sequencer state type, the shared-unit interface structs, constants and ppem_top_bit.
// No dependencies.
package ppem_pkg;

	localparam int unsigned MaxExponentsDefault = 32;
	localparam int unsigned MaskWidth           = 32;
	localparam int unsigned ValueWidth          = 32;
	localparam int unsigned MagWidth            = 31;
	localparam int unsigned RootBits            = 16;
	localparam int unsigned ProdWidth           = MagWidth + RootBits;
	localparam int unsigned CountWidth          = 6;
	localparam logic [CountWidth-1:0] CountReset = 6'd32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP,
		ST_CAND,
		ST_MUL,
		ST_CMP,
		ST_DONE
	} ppem_state_t;

	typedef struct packed {
		logic                en;
		logic [MagWidth-1:0] acc;
		logic [RootBits-1:0] base;
	} ppem_mul_ctl_t;

	typedef struct packed {
		logic                gt;
		logic                eq;
		logic [MagWidth-1:0] prod;
	} ppem_mul_sts_t;

	// Highest root bit that can matter for exponent e, since root^e < 2^31.
	function automatic logic [3:0] ppem_top_bit(input logic [CountWidth-1:0] e);
		logic [3:0] b;
		case (e) inside
			6'd2:          b = 4'd15;
			6'd3:          b = 4'd10;
			6'd4:          b = 4'd7;
			6'd5:          b = 4'd6;
			6'd6:          b = 4'd5;
			6'd7:          b = 4'd4;
			[6'd8:6'd10]:  b = 4'd3;
			[6'd11:6'd15]: b = 4'd2;
			[6'd16:6'd30]: b = 4'd1;
			default:       b = 4'd0;
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/ppem_mul.sv
// Shared multiply and compare unit of the perfect power exponent mask block.
// Registers acc * base, then compares the product against the tested value.
// Depends on ppem_pkg.
module ppem_mul
	import ppem_pkg::*;
(
	input  logic                clk,
	input  ppem_mul_ctl_t       ctl,
	input  logic [MagWidth-1:0] value,
	output ppem_mul_sts_t       sts
);

	logic [ProdWidth-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= ProdWidth'(ctl.acc) * ProdWidth'(ctl.base);
		end
	end

	assign sts.gt   = prod_q > ProdWidth'(value);
	assign sts.eq   = prod_q == ProdWidth'(value);
	assign sts.prod = prod_q[MagWidth-1:0];

endmodule

FILE: hw/rtl/ppem_seq.sv
// Sequencer of the perfect power exponent mask block.
// Walks exponents, root bits and multiplications, driving the shared unit ppem_mul.
// Depends on ppem_pkg.
module ppem_seq
	import ppem_pkg::*;
#(
	parameter int unsigned MAX_EXPONENTS = MaxExponentsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ValueWidth-1:0] value,
	input  logic [CountWidth-1:0] count,
	input  logic                  out_free,
	input  ppem_mul_sts_t         sts,
	output ppem_mul_ctl_t         ctl,
	output logic [MagWidth-1:0]   value_mag,
	output logic                  ready,
	output logic                  done,
	output logic [MaskWidth-1:0]  mask
);

	localparam int unsigned Limit = (MAX_EXPONENTS < MaskWidth) ? MAX_EXPONENTS : MaskWidth;

	ppem_state_t           state_q, state_d;
	logic [MagWidth-1:0]   value_q;
	logic [CountWidth-1:0] cnt_q;
	logic [4:0]            idx_q;
	logic [3:0]            bit_q;
	logic [RootBits-1:0]   root_q;
	logic [RootBits-1:0]   cand_q;
	logic [MagWidth-1:0]   acc_q;
	logic [CountWidth-1:0] k_q;
	logic                  eq_q;
	logic [MaskWidth-1:0]  mask_q;

	logic [CountWidth-1:0] cnt_eff;
	logic                  trivial;
	logic [CountWidth-1:0] exp_w;
	logic [CountWidth-1:0] k_inc;
	logic                  more_mul;
	logic                  accept;
	logic                  eq_new;
	logic                  last_idx;

	assign cnt_eff  = (count > CountWidth'(Limit)) ? CountWidth'(Limit) : count;
	assign trivial  = value[ValueWidth-1] | (value == '0) | (cnt_eff == '0);
	assign exp_w    = CountWidth'(idx_q) + 6'd2;
	assign k_inc    = k_q + 6'd1;
	assign more_mul = !sts.gt && (k_inc != exp_w);
	assign accept   = !sts.gt && (k_inc == exp_w);
	assign eq_new   = eq_q | (accept & sts.eq);
	assign last_idx = (CountWidth'(idx_q) + 6'd1) == cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = trivial ? ST_DONE : ST_EXP;
				end
			end
			ST_EXP:  state_d = ST_CAND;
			ST_CAND: state_d = ST_MUL;
			ST_MUL:  state_d = ST_CMP;
			ST_CMP: begin
				if (more_mul) begin
					state_d = ST_MUL;
				end else if (bit_q != 4'd0) begin
					state_d = ST_CAND;
				end else if (last_idx) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EXP;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready    = 1'b0;
		done     = 1'b0;
		ctl.en   = 1'b0;
		ctl.acc  = acc_q;
		ctl.base = cand_q;
		case (state_q)
			ST_IDLE: ready  = 1'b1;
			ST_MUL:  ctl.en = 1'b1;
			ST_DONE: done   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					value_q <= value[MagWidth-1:0];
					cnt_q   <= cnt_eff;
					idx_q   <= '0;
					mask_q  <= '0;
				end
			end
			ST_EXP: begin
				bit_q  <= ppem_top_bit(exp_w);
				root_q <= '0;
				eq_q   <= 1'b0;
			end
			ST_CAND: begin
				cand_q <= root_q | (RootBits'(1) << bit_q);
				acc_q  <= MagWidth'(1);
				k_q    <= '0;
			end
			ST_CMP: begin
				if (more_mul) begin
					acc_q <= sts.prod;
					k_q   <= k_inc;
				end else begin
					if (accept) begin
						root_q <= cand_q;
					end
					eq_q <= eq_new;
					if (bit_q == 4'd0) begin
						mask_q[idx_q] <= eq_new;
						idx_q         <= idx_q + 5'd1;
					end else begin
						bit_q <= bit_q - 4'd1;
					end
				end
			end
			default: ;
		endcase
	end

	assign value_mag = value_q;
	assign mask      = mask_q;

endmodule

FILE: hw/rtl/perfect_power_exponent_mask.sv
// Top level of the perfect power exponent mask block.
// Holds the exponent count register and the output register; depends on ppem_pkg,
// ppem_seq and ppem_mul.
//
//   channel | signals                     | word
//   input   | s_tvalid s_tready s_tdata   | value, signed, bits 31:0
//   output  | m_tvalid m_tready m_tdata   | power_mask, bits 31:0
//   config  | cfg_valid cfg_ready cfg_data| exponent_count, bits 5:0
//
// A non-positive word, or one under a count of zero, goes straight to the final state.
// Otherwise each exponent e passes one EXP state, then for each of its root bits one
// CAND state and a MUL, CMP pair for every multiplication on the shared multiplier
// (at most e per bit), and the word ends in the DONE state.
// Reset clears the sequencer, the output valid flag and sets the count to 32.
// A new word is taken while a result waits; a stalled output holds the block in its
// final state.
module perfect_power_exponent_mask
	import ppem_pkg::*;
#(
	parameter int unsigned MAX_EXPONENTS = MaxExponentsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ValueWidth-1:0] s_tdata,   // value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [MaskWidth-1:0]  m_tdata,   // power_mask
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data   // exponent_count in bits 5:0
);

	logic [CountWidth-1:0] exponent_count_q;
	logic                  out_valid_q;
	logic [MaskWidth-1:0]  out_data_q;
	logic                  out_free;
	logic                  seq_ready;
	logic                  seq_done;
	logic [MaskWidth-1:0]  seq_mask;
	logic [MagWidth-1:0]   value_mag;
	ppem_mul_ctl_t         mul_ctl;
	ppem_mul_sts_t         mul_sts;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = seq_ready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_count_q <= CountReset;
		end else if (cfg_valid && cfg_ready) begin
			exponent_count_q <= cfg_data[CountWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_data_q <= seq_mask;
		end
	end

	ppem_seq #(
		.MAX_EXPONENTS(MAX_EXPONENTS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && seq_ready),
		.value    (s_tdata),
		.count    (exponent_count_q),
		.out_free (out_free),
		.sts      (mul_sts),
		.ctl      (mul_ctl),
		.value_mag(value_mag),
		.ready    (seq_ready),
		.done     (seq_done),
		.mask     (seq_mask)
	);

	ppem_mul u_mul (
		.clk  (clk),
		.ctl  (mul_ctl),
		.value(value_mag),
		.sts  (mul_sts)
	);

`ifndef NO_ASSERTIONS
	a_done_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> (!m_tvalid || m_tready))
		else $error("result finished while the output register was full");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after an accepted word");

	a_mask_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((64'(m_tdata) >> exponent_count_q) == 64'd0))
		else $error("mask bit set beyond the exponent count");
`endif

endmodule

FILE: tb/perfect_power_exponent_mask_tb.sv
// Testbench for perfect_power_exponent_mask: a directed table, then random values.
// Each result word is checked against a typed table mask or an in-bench perfect power predictor.
// Depends on ppem_pkg and the perfect_power_exponent_mask RTL.
module perfect_power_exponent_mask_tb;
	import ppem_pkg::*;

	localparam int unsigned MAX_EXP        = MaxExponentsDefault;
	localparam int unsigned PHASE_WORDS    = 53;
	localparam int unsigned HOLD_CYCLES    = 600;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned TAIL_CYCLES    = 100;
	localparam int unsigned WATCHDOG_LIMIT = 40000;

	typedef enum {ORDER_BELOW, ORDER_EQUAL, ORDER_ABOVE} order_t;

	typedef struct packed {
		logic [CountWidth-1:0] count;
		logic [ValueWidth-1:0] value;
		bit                    typed;
		logic [MaskWidth-1:0]  mask;
	} directed_row_t;

	typedef struct packed {
		logic [CountWidth-1:0] count;
		bit                    idling;
		bit                    hold;
	} phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [ValueWidth-1:0] s_tdata;   // value
	logic                  m_tvalid;
	logic                  m_tready;
	logic [MaskWidth-1:0]  m_tdata;   // power_mask
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [7:0]            cfg_data;  // exponent_count in bits 5:0

	logic [MaskWidth-1:0]  expected_masks [$];
	logic [CountWidth-1:0] active_count = CountReset;
	int unsigned           mismatch_count = 0;
	bit                    idle_on = 1'b1;
	bit                    hold_request = 1'b0;

	directed_row_t directed_rows [24] = '{
		'{6'd32, 32'd1,          1'b1, 32'hFFFF_FFFF},
		'{6'd32, 32'd0,          1'b1, 32'h0},
		'{6'd32, 32'hFFFF_FFFF,  1'b1, 32'h0},
		'{6'd32, 32'h8000_0000,  1'b1, 32'h0},
		'{6'd32, 32'h7FFF_FFFF,  1'b0, 32'h0},
		'{6'd32, 32'd4,          1'b1, 32'h1},
		'{6'd32, 32'd8,          1'b1, 32'h2},
		'{6'd32, 32'd64,         1'b1, 32'h13},
		'{6'd32, 32'h4000_0000,  1'b0, 32'h0},
		'{6'd32, 32'd2147395600, 1'b0, 32'h0},
		'{6'd32, 32'd2147395601, 1'b0, 32'h0},
		'{6'd32, 32'd2146689000, 1'b0, 32'h0},
		'{6'd32, 32'd2,          1'b1, 32'h0},
		'{6'd32, 32'd3,          1'b1, 32'h0},
		'{6'd0,  32'd1,          1'b1, 32'h0},
		'{6'd0,  32'd64,         1'b1, 32'h0},
		'{6'd1,  32'd1,          1'b1, 32'h1},
		'{6'd1,  32'd9,          1'b1, 32'h1},
		'{6'd1,  32'd8,          1'b1, 32'h0},
		'{6'd63, 32'd1,          1'b1, 32'hFFFF_FFFF},
		'{6'd63, 32'h8000_0001,  1'b1, 32'h0},
		'{6'd33, 32'd1,          1'b1, 32'hFFFF_FFFF},
		'{6'd33, 32'd65536,      1'b0, 32'h0},
		'{6'd2,  32'd27,         1'b1, 32'h2}
	};

	phase_t random_phases [10] = '{
		'{6'd2,  1'b1, 1'b1},
		'{6'd1,  1'b1, 1'b0},
		'{6'd5,  1'b0, 1'b0},
		'{6'd32, 1'b1, 1'b0},
		'{6'd3,  1'b1, 1'b0},
		'{6'd0,  1'b1, 1'b0},
		'{6'd63, 1'b1, 1'b0},
		'{6'd12, 1'b1, 1'b0},
		'{6'd33, 1'b0, 1'b0},
		'{6'd7,  1'b1, 1'b1}
	};

	perfect_power_exponent_mask #(
		.MAX_EXPONENTS(MAX_EXP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic order_t compare_power(input longint unsigned root,
			input int unsigned exponent, input longint unsigned value);
		longint unsigned acc;
		acc = 1;
		for (int unsigned k = 0; k < exponent; k++) begin
			acc = acc * root;
			if (acc > value)
				return ORDER_ABOVE;
		end
		return (acc == value) ? ORDER_EQUAL : ORDER_BELOW;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned value,
			input int unsigned exponent);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = RootBits - 1; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (compare_power(t, exponent, value) != ORDER_ABOVE)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [MaskWidth-1:0] power_mask_of(input logic [ValueWidth-1:0] value,
			input logic [CountWidth-1:0] count);
		logic [MaskWidth-1:0] mask;
		int unsigned          tested;
		longint unsigned      r;
		mask = '0;
		tested = count;
		if (tested > MAX_EXP)
			tested = MAX_EXP;
		if (tested > MaskWidth)
			tested = MaskWidth;
		if (!value[ValueWidth-1] && value != '0) begin
			for (int unsigned i = 0; i < tested; i++) begin
				r = root_floor(value, i + 2);
				if (r != 0 && compare_power(r, i + 2, value) == ORDER_EQUAL)
					mask[i] = 1'b1;
			end
		end
		return mask;
	endfunction

	function automatic int unsigned gap_length();
		int unsigned roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ValueWidth-1:0] draw_value();
		int unsigned          roll;
		int unsigned          e_top;
		int unsigned          exponent;
		longint unsigned      root;
		logic [ValueWidth-1:0] power;
		roll = $urandom_range(0, 99);
		e_top = active_count + 1;
		if (e_top > MAX_EXP + 1)
			e_top = MAX_EXP + 1;
		if (e_top < 2)
			e_top = 2;
		exponent = $urandom_range(2, e_top);
		root = $urandom_range(1, root_floor(32'h7FFF_FFFF, exponent));
		power = 1;
		repeat (exponent) power = ValueWidth'(power * root);
		if (roll < 45)
			return power;
		if (roll < 60)
			return $urandom_range(0, 1) ? power + 1 : power - 1;
		if (roll < 80)
			return $urandom;
		if (roll < 90)
			return $urandom_range(0, 1000);
		if (roll < 95)
			return {1'b1, 31'($urandom)};
		return '0;
	endfunction

	task automatic check_word(input logic [MaskWidth-1:0] got);
		logic [MaskWidth-1:0] want;
		if (expected_masks.size() == 0) begin
			$display("%0t: power_mask expected none, got %h", $time, got);
			mismatch_count++;
		end else begin
			want = expected_masks.pop_front();
			if (got !== want) begin
				$display("%0t: power_mask expected %h, got %h", $time, want, got);
				mismatch_count++;
			end
		end
	endtask

	task automatic send_value(input logic [ValueWidth-1:0] value,
			input logic [MaskWidth-1:0] want, input bit end_of_run);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		expected_masks = {expected_masks, want};
		gap = gap_length();
		if (gap != 0 || end_of_run) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		while (expected_masks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CountWidth-1:0] count);
		cfg_valid <= 1'b1;
		cfg_data <= {2'($urandom), count};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_count = count;
	endtask

	initial begin : receiver
		int unsigned stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				check_word(m_tdata);
				stall = gap_length();
			end else if (stall == 0 && idle_on && $urandom_range(0, 15) == 0) begin
				stall = gap_length();
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		directed_row_t         row;
		logic [ValueWidth-1:0] value;
		bit                    end_of_run;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.count != active_count) begin
				settle();
				write_count(row.count);
			end
			end_of_run = (i == $size(directed_rows) - 1) ||
				(directed_rows[i + 1].count != row.count);
			send_value(row.value, row.typed ? row.mask : power_mask_of(row.value, active_count),
				end_of_run);
		end

		foreach (random_phases[p]) begin
			settle();
			write_count(random_phases[p].count);
			idle_on = random_phases[p].idling;
			if (random_phases[p].hold)
				hold_request = 1'b1;
			for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
				value = draw_value();
				send_value(value, power_mask_of(value, active_count), n == PHASE_WORDS - 1);
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/ppem_pkg.sv
hw/rtl/ppem_mul.sv
hw/rtl/ppem_seq.sv
hw/rtl/perfect_power_exponent_mask.sv
tb/perfect_power_exponent_mask_tb.sv
